/* sv/dro_pkg.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// dro_pkg
// Types, constants and the control store of the DRO v1 capture encoder.
// ---------------------------------------------------------------------------
package dro_pkg;

  localparam int unsigned MPT_W   = 24;
  localparam int unsigned TICKS_W = 12;
  localparam int unsigned PROD_W  = MPT_W + TICKS_W;
  localparam int unsigned ACC_W   = 48;
  localparam int unsigned D_W     = 21;
  localparam int unsigned STEP_W  = 5;

  localparam logic [D_W-1:0] CHUNK_MS  = 21'd65536;
  localparam logic [D_W-1:0] DELAY_CAP = 21'd1114112;
  localparam logic [D_W-1:0] SHORT_MAX = 21'd256;
  localparam logic [7:0]     ESC_BYTE  = 8'd4;
  localparam logic [7:0]     ESC_MAX   = 8'd4;
  localparam logic [7:0]     CHIP_BASE = 8'd2;
  localparam logic [7:0]     BYTE_ONE  = 8'd1;
  localparam logic [7:0]     BYTE_FF   = 8'd255;
  localparam logic [7:0]     BYTE_ZERO = 8'd0;

  typedef logic [STEP_W-1:0] step_t;

  typedef enum logic [3:0] {
    SRC_NONE,
    SRC_CHIP,
    SRC_ESC,
    SRC_REG,
    SRC_VAL,
    SRC_ONE,
    SRC_FF,
    SRC_ZERO,
    SRC_DLO,
    SRC_DHI
  } src_t;

  typedef enum logic [3:0] {
    DP_NOP,
    DP_SET_CHIP,
    DP_MUL,
    DP_ACC,
    DP_RND,
    DP_DIFF,
    DP_SAT,
    DP_CHUNK,
    DP_DEC
  } dp_t;

  typedef enum logic [2:0] {
    C_NEVER,
    C_ALWAYS,
    C_CHIP_SAME,
    C_REG_HIGH,
    C_D_ZERO,
    C_NO_CHUNK,
    C_SHORT
  } cond_t;

  typedef struct packed {
    src_t  src;
    logic  last;
    logic  fin;
    dp_t   dp;
    cond_t cond;
    step_t target;
  } ctrl_t;

  typedef struct packed {
    logic chip_same;
    logic reg_high;
    logic d_zero;
    logic no_chunk;
    logic short_d;
  } cond_flags_t;

  localparam step_t S_W_CHIPCHK = 5'd0;
  localparam step_t S_W_CHIP    = 5'd1;
  localparam step_t S_W_ESCCHK  = 5'd2;
  localparam step_t S_W_ESC     = 5'd3;
  localparam step_t S_W_REG     = 5'd4;
  localparam step_t S_W_VAL     = 5'd5;
  localparam step_t S_D_MUL     = 5'd6;
  localparam step_t S_D_ACC     = 5'd7;
  localparam step_t S_D_RND     = 5'd8;
  localparam step_t S_D_DIFF    = 5'd9;
  localparam step_t S_D_SAT     = 5'd10;
  localparam step_t S_D_LOOP    = 5'd11;
  localparam step_t S_D_C1      = 5'd12;
  localparam step_t S_D_C2      = 5'd13;
  localparam step_t S_D_C3      = 5'd14;
  localparam step_t S_D_REST    = 5'd15;
  localparam step_t S_D_L1      = 5'd16;
  localparam step_t S_D_L2      = 5'd17;
  localparam step_t S_D_L3      = 5'd18;
  localparam step_t S_D_S1      = 5'd19;
  localparam step_t S_D_S2      = 5'd20;
  localparam step_t S_D_END     = 5'd21;

  function automatic ctrl_t mk(src_t src, logic last, logic fin, dp_t dp,
                               cond_t cond, step_t target);
    ctrl_t w;
    w.src    = src;
    w.last   = last;
    w.fin    = fin;
    w.dp     = dp;
    w.cond   = cond;
    w.target = target;
    return w;
  endfunction

  function automatic ctrl_t rom_word(step_t s);
    ctrl_t w;
    case (s)
      S_W_CHIPCHK: w = mk(SRC_NONE, 1'b0, 1'b0, DP_NOP,      C_CHIP_SAME, S_W_ESCCHK);
      S_W_CHIP:    w = mk(SRC_CHIP, 1'b0, 1'b0, DP_SET_CHIP, C_NEVER,     S_W_CHIPCHK);
      S_W_ESCCHK:  w = mk(SRC_NONE, 1'b0, 1'b0, DP_NOP,      C_REG_HIGH,  S_W_REG);
      S_W_ESC:     w = mk(SRC_ESC,  1'b0, 1'b0, DP_NOP,      C_NEVER,     S_W_CHIPCHK);
      S_W_REG:     w = mk(SRC_REG,  1'b0, 1'b0, DP_NOP,      C_NEVER,     S_W_CHIPCHK);
      S_W_VAL:     w = mk(SRC_VAL,  1'b1, 1'b1, DP_NOP,      C_NEVER,     S_W_CHIPCHK);
      S_D_MUL:     w = mk(SRC_NONE, 1'b0, 1'b0, DP_MUL,      C_NEVER,     S_W_CHIPCHK);
      S_D_ACC:     w = mk(SRC_NONE, 1'b0, 1'b0, DP_ACC,      C_NEVER,     S_W_CHIPCHK);
      S_D_RND:     w = mk(SRC_NONE, 1'b0, 1'b0, DP_RND,      C_NEVER,     S_W_CHIPCHK);
      S_D_DIFF:    w = mk(SRC_NONE, 1'b0, 1'b0, DP_DIFF,     C_NEVER,     S_W_CHIPCHK);
      S_D_SAT:     w = mk(SRC_NONE, 1'b0, 1'b0, DP_SAT,      C_D_ZERO,    S_D_END);
      S_D_LOOP:    w = mk(SRC_NONE, 1'b0, 1'b0, DP_NOP,      C_NO_CHUNK,  S_D_REST);
      S_D_C1:      w = mk(SRC_ONE,  1'b0, 1'b0, DP_NOP,      C_NEVER,     S_W_CHIPCHK);
      S_D_C2:      w = mk(SRC_FF,   1'b0, 1'b0, DP_NOP,      C_NEVER,     S_W_CHIPCHK);
      S_D_C3:      w = mk(SRC_FF,   1'b0, 1'b0, DP_CHUNK,    C_ALWAYS,    S_D_LOOP);
      S_D_REST:    w = mk(SRC_NONE, 1'b0, 1'b0, DP_DEC,      C_SHORT,     S_D_S1);
      S_D_L1:      w = mk(SRC_ONE,  1'b0, 1'b0, DP_NOP,      C_NEVER,     S_W_CHIPCHK);
      S_D_L2:      w = mk(SRC_DLO,  1'b0, 1'b0, DP_NOP,      C_NEVER,     S_W_CHIPCHK);
      S_D_L3:      w = mk(SRC_DHI,  1'b1, 1'b1, DP_NOP,      C_NEVER,     S_W_CHIPCHK);
      S_D_S1:      w = mk(SRC_ZERO, 1'b0, 1'b0, DP_NOP,      C_NEVER,     S_W_CHIPCHK);
      S_D_S2:      w = mk(SRC_DLO,  1'b1, 1'b1, DP_NOP,      C_NEVER,     S_W_CHIPCHK);
      S_D_END:     w = mk(SRC_NONE, 1'b0, 1'b1, DP_NOP,      C_NEVER,     S_W_CHIPCHK);
      default:     w = mk(SRC_NONE, 1'b0, 1'b1, DP_NOP,      C_NEVER,     S_W_CHIPCHK);
    endcase
    return w;
  endfunction

endpackage
`default_nettype wire

/* sv/dro_seq.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// dro_seq
// Step counter and control store; one control word per step, with
// conditional jumps on datapath flags.
// ---------------------------------------------------------------------------
module dro_seq (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  input  wire dro_pkg::step_t       entry,
  input  wire dro_pkg::cond_flags_t flags,
  input  wire logic                 out_free,
  output dro_pkg::ctrl_t            ctrl,
  output logic                      fire,
  output logic                      busy
);

  dro_pkg::step_t step_r, step_nxt;
  logic           busy_r, busy_nxt;
  logic           taken;

  assign ctrl = dro_pkg::rom_word(step_r);
  assign busy = busy_r;
  assign fire = busy_r && ((ctrl.src == dro_pkg::SRC_NONE) || out_free);

  always_comb begin
    case (ctrl.cond)
      dro_pkg::C_NEVER:     taken = 1'b0;
      dro_pkg::C_ALWAYS:    taken = 1'b1;
      dro_pkg::C_CHIP_SAME: taken = flags.chip_same;
      dro_pkg::C_REG_HIGH:  taken = flags.reg_high;
      dro_pkg::C_D_ZERO:    taken = flags.d_zero;
      dro_pkg::C_NO_CHUNK:  taken = flags.no_chunk;
      dro_pkg::C_SHORT:     taken = flags.short_d;
      default:              taken = 1'b0;
    endcase
  end

  always_comb begin
    step_nxt = step_r;
    busy_nxt = busy_r;
    if (start) begin
      step_nxt = entry;
      busy_nxt = 1'b1;
    end else if (fire) begin
      if (ctrl.fin) begin
        busy_nxt = 1'b0;
      end else if (taken) begin
        step_nxt = ctrl.target;
      end else begin
        step_nxt = step_r + 5'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= dro_pkg::S_W_CHIPCHK;
      busy_r <= 1'b0;
    end else begin
      step_r <= step_nxt;
      busy_r <= busy_nxt;
    end
  end

  a_no_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !busy_r)
    else $error("start while sequencer busy");

  a_fin_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && ctrl.fin && !start) |=> !busy_r)
    else $error("sequencer still busy after final step");

  a_entry_step: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> (busy_r && step_r == $past(entry)))
    else $error("sequencer did not load entry step");

endmodule
`default_nettype wire

/* sv/dro_opl_capture_encoder.sv */
`default_nettype none
// The first byte of a write is registered after the chip check, and after the escape
// check too when the chip is unchanged; that of a delay after the multiply through
// chunk loop steps, and the rest step as well when no chunk is due. Later bytes follow
// at up to one per cycle while the output does not stall, with a gap at the escape
// check after a chip byte and at the chunk loop and rest steps. A new item is taken only
// once the previous one is done. Reset clears ms_per_tick, time and chip state.
// ---------------------------------------------------------------------------
// dro_opl_capture_encoder
// Encodes OPL register writes and tick delays into DRO v1 body bytes.
// ---------------------------------------------------------------------------
module dro_opl_capture_encoder #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_wr_en,
  input  wire logic [23:0] cfg_wr_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        in_kind,
  input  wire logic [8:0]  in_reg_address,
  input  wire logic [7:0]  in_reg_value,
  input  wire logic [11:0] in_ticks,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       out_byte,
  output logic             out_last
);

  localparam int unsigned IBITS = ((48 - FRAC_BITS) > 32) ? 32 : (48 - FRAC_BITS);
  localparam logic [dro_pkg::ACC_W-1:0] HALF = 48'd1 << (FRAC_BITS - 1);

  logic [dro_pkg::MPT_W-1:0]   mpt_r;
  logic [dro_pkg::ACC_W-1:0]   acc_r;
  logic [IBITS-1:0]            emitted_r;
  logic                        chip_r;
  logic [dro_pkg::PROD_W-1:0]  prod_r;
  logic [IBITS-1:0]            rnd_r;
  logic [IBITS-1:0]            dfull_r;
  logic [dro_pkg::D_W-1:0]     d_r;
  logic [8:0]                  addr_r;
  logic [7:0]                  val_r;
  logic [dro_pkg::TICKS_W-1:0] ticks_r;

  logic                        out_valid_r;
  logic [7:0]                  out_byte_r;
  logic                        out_last_r;
  logic [7:0]                  byte_sel;

  logic                        start;
  logic                        out_free;
  logic                        fire;
  logic                        busy;
  dro_pkg::step_t              entry;
  dro_pkg::ctrl_t              ctrl;
  dro_pkg::cond_flags_t        flags;
  logic [dro_pkg::ACC_W-1:0]   rnd_sum;

  assign start    = in_valid && !busy;
  assign in_stall = busy;
  assign entry    = in_kind ? dro_pkg::S_D_MUL : dro_pkg::S_W_CHIPCHK;
  assign out_free = !out_valid_r || !out_stall;
  assign rnd_sum  = acc_r + HALF;

  assign flags.chip_same = (addr_r[8] == chip_r);
  assign flags.reg_high  = (addr_r[7:0] > dro_pkg::ESC_MAX);
  assign flags.d_zero    = (dfull_r == '0);
  assign flags.no_chunk  = (d_r <= dro_pkg::CHUNK_MS);
  assign flags.short_d   = (d_r <= dro_pkg::SHORT_MAX);

  dro_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .entry    (entry),
    .flags    (flags),
    .out_free (out_free),
    .ctrl     (ctrl),
    .fire     (fire),
    .busy     (busy)
  );

  always_comb begin
    case (ctrl.src)
      dro_pkg::SRC_CHIP: byte_sel = dro_pkg::CHIP_BASE | {7'd0, addr_r[8]};
      dro_pkg::SRC_ESC:  byte_sel = dro_pkg::ESC_BYTE;
      dro_pkg::SRC_REG:  byte_sel = addr_r[7:0];
      dro_pkg::SRC_VAL:  byte_sel = val_r;
      dro_pkg::SRC_ONE:  byte_sel = dro_pkg::BYTE_ONE;
      dro_pkg::SRC_FF:   byte_sel = dro_pkg::BYTE_FF;
      dro_pkg::SRC_ZERO: byte_sel = dro_pkg::BYTE_ZERO;
      dro_pkg::SRC_DLO:  byte_sel = d_r[7:0];
      dro_pkg::SRC_DHI:  byte_sel = d_r[15:8];
      default:           byte_sel = dro_pkg::BYTE_ZERO;
    endcase
  end

  // control and architectural state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mpt_r       <= '0;
      acc_r       <= '0;
      emitted_r   <= '0;
      chip_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        mpt_r <= cfg_wr_data;
      end
      if (fire && ctrl.dp == dro_pkg::DP_SET_CHIP) begin
        chip_r <= addr_r[8];
      end
      if (fire && ctrl.dp == dro_pkg::DP_ACC) begin
        acc_r <= acc_r + dro_pkg::ACC_W'(prod_r);
      end
      if (fire && ctrl.dp == dro_pkg::DP_DIFF) begin
        emitted_r <= rnd_r;
      end
      if (fire && ctrl.src != dro_pkg::SRC_NONE) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (start) begin
      addr_r  <= in_reg_address;
      val_r   <= in_reg_value;
      ticks_r <= in_ticks;
    end
    if (fire) begin
      case (ctrl.dp)
        dro_pkg::DP_MUL:   prod_r  <= dro_pkg::PROD_W'(ticks_r) * dro_pkg::PROD_W'(mpt_r);
        dro_pkg::DP_RND:   rnd_r   <= rnd_sum[FRAC_BITS +: IBITS];
        dro_pkg::DP_DIFF:  dfull_r <= rnd_r - emitted_r;
        dro_pkg::DP_SAT:   d_r     <= (32'(dfull_r) > 32'(dro_pkg::DELAY_CAP)) ?
                                      dro_pkg::DELAY_CAP : dro_pkg::D_W'(dfull_r);
        dro_pkg::DP_CHUNK: d_r     <= d_r - dro_pkg::CHUNK_MS;
        dro_pkg::DP_DEC:   d_r     <= d_r - 21'd1;
        default: begin
        end
      endcase
    end
    if (fire && ctrl.src != dro_pkg::SRC_NONE) begin
      out_byte_r <= byte_sel;
      out_last_r <= ctrl.last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_byte  = out_byte_r;
  assign out_last  = out_last_r;

  a_stall_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input not stalled after transfer");

  a_last_on_final: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && ctrl.fin && ctrl.src != dro_pkg::SRC_NONE) |=> (out_valid && out_last))
    else $error("final byte not marked last");

  a_long_code_range: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && ctrl.src == dro_pkg::SRC_DHI) |-> (d_r[20:16] == 5'd0))
    else $error("long delay code out of range");

endmodule
`default_nettype wire

/* test/dro_stream_checker.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// DRO stream checker
// Watches the item, result and register ports of the DRO v1 capture encoder.
// Keeps its own copy of the time and chip state, works out the body bytes
// each accepted item must produce, and compares every result transfer with
// the oldest byte still due. Reports the mismatch count and the number of
// bytes still owed.
// ---------------------------------------------------------------------------
module dro_stream_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [23:0] cfg_wr_data,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic        in_kind,
  input  logic [8:0]  in_reg_address,
  input  logic [7:0]  in_reg_value,
  input  logic [11:0] in_ticks,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [7:0]  out_byte,
  input  logic        out_last,
  output int          fail_count,
  output int          bytes_pending
);

  localparam int   FRAC       = 16;
  localparam logic KIND_WRITE = 1'b0;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } stream_byte_t;

  stream_byte_t bytes_due[$];
  logic [7:0]   burst[$];
  stream_byte_t want;

  logic [23:0] ms_per_tick = '0;
  logic [47:0] elapsed_q   = '0;
  logic [31:0] emitted_ms  = '0;
  logic        cur_chip    = 1'b0;
  int          mismatches  = 0;
  int          pending_q   = 0;

  assign fail_count    = mismatches;
  assign bytes_pending = pending_q;

  function automatic void predict_write(input logic [8:0] addr, input logic [7:0] val);
    if (addr[8] != cur_chip) begin
      cur_chip = addr[8];
      burst.push_back(dro_pkg::CHIP_BASE + 8'(addr[8]));
    end
    if (addr[7:0] <= dro_pkg::ESC_MAX) begin
      burst.push_back(dro_pkg::ESC_BYTE);
    end
    burst.push_back(addr[7:0]);
    burst.push_back(val);
  endfunction

  function automatic void predict_delay(input logic [11:0] ticks);
    logic [47:0] biased;
    logic [31:0] rounded;
    logic [31:0] growth;
    logic [31:0] rest;
    if (ticks == 12'd0) return;
    elapsed_q  = elapsed_q + 48'(ticks) * 48'(ms_per_tick);
    biased     = elapsed_q + (48'd1 << (FRAC - 1));
    rounded    = 32'(biased >> FRAC);
    growth     = rounded - emitted_ms;
    emitted_ms = emitted_ms + growth;
    if (growth == 32'd0) return;
    // drop time beyond the cap
    rest = (growth > 32'(dro_pkg::DELAY_CAP)) ? 32'(dro_pkg::DELAY_CAP) : growth;
    while (rest > 32'(dro_pkg::CHUNK_MS)) begin
      burst.push_back(dro_pkg::BYTE_ONE);
      burst.push_back(dro_pkg::BYTE_FF);
      burst.push_back(dro_pkg::BYTE_FF);
      rest = rest - 32'(dro_pkg::CHUNK_MS);
    end
    rest = rest - 32'd1;
    if (rest <= 32'd255) begin
      burst.push_back(dro_pkg::BYTE_ZERO);
      burst.push_back(rest[7:0]);
    end else begin
      burst.push_back(dro_pkg::BYTE_ONE);
      burst.push_back(rest[7:0]);
      burst.push_back(rest[15:8]);
    end
  endfunction

  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_wr_en) begin
        ms_per_tick = cfg_wr_data;
      end
      if (in_valid && !in_stall) begin
        burst.delete();
        if (in_kind == KIND_WRITE) begin
          predict_write(in_reg_address, in_reg_value);
        end else begin
          predict_delay(in_ticks);
        end
        foreach (burst[i]) begin
          bytes_due.push_back('{data: burst[i], last: (i == burst.size() - 1)});
        end
      end
      if (out_valid && !out_stall) begin
        if (bytes_due.size() == 0) begin
          $display("%0t: unexpected transfer: expected none, got byte %0d last %0b",
                   $time, out_byte, out_last);
          mismatches++;
        end else begin
          want = bytes_due.pop_front();
          if (out_byte !== want.data) begin
            $display("%0t: out_byte expected %0d, got %0d", $time, want.data, out_byte);
            mismatches++;
          end
          if (out_last !== want.last) begin
            $display("%0t: out_last expected %0b, got %0b", $time, want.last, out_last);
            mismatches++;
          end
        end
      end
    end
    pending_q <= bytes_due.size();
  end

endmodule

/* test/tb.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// DRO capture encoder testbench
// Drives register writes and tick delays into the encoder under random
// sender gaps and receiver stalls, across several ms_per_tick settings from
// zero to full scale, and finishes with a run of full-scale delays of many
// chunks each. The checker beside the block predicts and compares every byte.
// ---------------------------------------------------------------------------
module tb;

  localparam int   CYCLE_LIMIT   = 2000000;
  localparam int   SETTLE_CYCLES = 24;
  localparam int   RANDOM_ITEMS  = 50;
  localparam int   LONG_DELAYS   = 10;
  localparam logic KIND_WRITE    = 1'b0;
  localparam logic KIND_DELAY    = 1'b1;

  logic        clk            = 1'b0;
  logic        rst_n          = 1'b0;
  logic        cfg_wr_en      = 1'b0;
  logic [23:0] cfg_wr_data    = '0;
  logic        in_valid       = 1'b0;
  logic        in_kind        = KIND_WRITE;
  logic [8:0]  in_reg_address = '0;
  logic [7:0]  in_reg_value   = '0;
  logic [11:0] in_ticks       = '0;
  logic        out_stall      = 1'b0;
  logic        in_stall;
  logic        out_valid;
  logic [7:0]  out_byte;
  logic        out_last;

  int send_idle_pct = 0;
  int stall_pct     = 0;
  int cycle_count   = 0;
  int fail_count;
  int bytes_pending;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  dro_opl_capture_encoder dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_kind       (in_kind),
    .in_reg_address(in_reg_address),
    .in_reg_value  (in_reg_value),
    .in_ticks      (in_ticks),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_byte      (out_byte),
    .out_last      (out_last)
  );

  dro_stream_checker stream_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_kind       (in_kind),
    .in_reg_address(in_reg_address),
    .in_reg_value  (in_reg_value),
    .in_ticks      (in_ticks),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_byte      (out_byte),
    .out_last      (out_last),
    .fail_count    (fail_count),
    .bytes_pending (bytes_pending)
  );

  always @(posedge clk) begin
    out_stall   <= ($urandom_range(99) < stall_pct);
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic put_item(input logic kind, input logic [8:0] addr,
                          input logic [7:0] val, input logic [11:0] ticks);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_kind        <= kind;
    in_reg_address <= addr;
    in_reg_value   <= val;
    in_ticks       <= ticks;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic put_write(input logic chip, input logic [7:0] reg_sel, input logic [7:0] val);
    put_item(KIND_WRITE, {chip, reg_sel}, val, 12'($urandom));
  endtask

  task automatic put_delay(input logic [11:0] ticks);
    put_item(KIND_DELAY, 9'($urandom), 8'($urandom), ticks);
  endtask

  // hold until every byte due has come, then let the block go idle
  task automatic settle_stream;
    in_valid <= 1'b0;
    do @(negedge clk); while (bytes_pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic load_ms_per_tick(input logic [23:0] value);
    settle_stream();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  task automatic random_item;
    logic [7:0]  reg_sel;
    logic [11:0] ticks;
    if ($urandom_range(99) < 55) begin
      reg_sel = ($urandom_range(99) < 30) ? 8'($urandom_range(4)) : 8'($urandom);
      put_write(1'($urandom), reg_sel, 8'($urandom));
    end else begin
      case ($urandom_range(9))
        0:          ticks = 12'd0;
        1, 2, 3, 4: ticks = 12'($urandom_range(300, 1));
        default:    ticks = 12'($urandom);
      endcase
      put_delay(ticks);
    end
    if ($urandom_range(99) < 2) begin
      settle_stream();
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    send_idle_pct = 31;
    stall_pct     = 69;

    // ms_per_tick still zero from reset
    put_delay(12'd5);
    load_ms_per_tick(24'h010000);
    put_write(1'b0, 8'h00, 8'h00);
    put_write(1'b0, 8'h04, 8'hFF);
    put_write(1'b0, 8'h05, 8'h5A);
    put_write(1'b0, 8'hFF, 8'hA5);
    put_write(1'b1, 8'h01, 8'h3C);
    put_write(1'b1, 8'hBD, 8'h00);
    put_write(1'b0, 8'h03, 8'h81);
    put_delay(12'd0);
    put_delay(12'd1);
    put_delay(12'd256);
    put_delay(12'd257);
    put_delay(12'hFFF);
    // tiny step: rounds to zero
    load_ms_per_tick(24'h000001);
    put_delay(12'd1);
    put_delay(12'hFFF);
    load_ms_per_tick(24'h008000);
    put_delay(12'd1);
    put_delay(12'd3);
    // exactly one chunk, then one chunk and a short rest
    load_ms_per_tick(24'h200000);
    put_delay(12'd2048);
    put_delay(12'd2049);
    load_ms_per_tick(24'hFFFFFF);
    put_delay(12'hFFF);
    put_delay(12'd1);

    load_ms_per_tick(24'($urandom_range(24'h03FFFF, 1)));
    for (int i = 0; i < RANDOM_ITEMS; i++) random_item();

    send_idle_pct = 69;
    stall_pct     = 31;
    load_ms_per_tick(24'hFFFFFF);
    for (int i = 0; i < RANDOM_ITEMS; i++) random_item();

    send_idle_pct = 0;
    stall_pct     = 0;
    load_ms_per_tick(24'($urandom));
    for (int i = 0; i < RANDOM_ITEMS; i++) random_item();

    // full-scale delays, many chunks each
    load_ms_per_tick(24'hFFFFFF);
    repeat (LONG_DELAYS) put_delay(12'hFFF);

    settle_stream();
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
